[hdl/char_lcd_4bit_command_sequencer_macros.svh]
// Assertion helpers; the using scope must provide clk and rst.
`ifndef CHAR_LCD_4BIT_COMMAND_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_COMMAND_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCD4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCD4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lcd4_pkg.sv]
package lcd4_pkg;

  typedef enum logic [2:0] {
    KIND_INIT  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_POS   = 3'd2,
    KIND_CTRL  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  localparam int unsigned INIT_STEPS = 13;
  localparam int unsigned IDX_W      = 4;

  localparam logic [7:0] BYTE_FUNC_SET  = 8'h28;
  localparam logic [7:0] BYTE_DISP_CTRL = 8'h08;
  localparam logic [7:0] BYTE_CLEAR     = 8'h01;
  localparam logic [7:0] BYTE_ENTRY     = 8'h06;
  localparam logic [7:0] BYTE_SET_DDRAM = 8'h80;
  localparam logic [7:0] LINE2_OFFSET   = 8'h40;
  localparam logic [3:0] NIB_RESET      = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;

  localparam logic [7:0] WAIT_NONE     = 8'd0;
  localparam logic [7:0] WAIT_SHORT    = 8'd4;
  localparam logic [7:0] WAIT_CLEAR    = 8'd41;
  localparam logic [7:0] WAIT_LONG     = 8'd50;
  localparam logic [7:0] WAIT_POWER_UP = 8'd200;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [4:0] column;
    logic [1:0] row;
    logic       display_on;
    logic       cursor_shown;
    logic       cursor_blink;
  } req_t;

  typedef struct packed {
    logic       strobe_res;
    logic       reg_select;
    logic [3:0] nibble;
    logic [7:0] wait_ticks;
    logic       last;
  } step_t;

  // controller -> datapath
  typedef struct packed {
    logic             capture;
    logic             load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind_ok;
    logic out_free;
    logic step_last;
  } status_t;

  function automatic step_t mk_step(logic strobe, logic [3:0] nib, logic [7:0] wt,
                                    logic lst);
    step_t s;
    s.strobe_res = strobe;
    s.reg_select = 1'b0;
    s.nibble     = nib;
    s.wait_ticks = wt;
    s.last       = lst;
    return s;
  endfunction

  // Power-up sequence, all to the instruction register.
  function automatic step_t init_step(logic [IDX_W-1:0] idx);
    step_t s;
    unique case (idx)
      4'd0:    s = mk_step(1'b0, 4'h0, WAIT_POWER_UP, 1'b0);
      4'd1:    s = mk_step(1'b1, NIB_RESET, WAIT_LONG, 1'b0);
      4'd2:    s = mk_step(1'b1, NIB_RESET, WAIT_LONG, 1'b0);
      4'd3:    s = mk_step(1'b1, NIB_RESET, WAIT_LONG, 1'b0);
      4'd4:    s = mk_step(1'b1, NIB_4BIT, WAIT_SHORT, 1'b0);
      4'd5:    s = mk_step(1'b1, BYTE_FUNC_SET[7:4], WAIT_NONE, 1'b0);
      4'd6:    s = mk_step(1'b1, BYTE_FUNC_SET[3:0], WAIT_SHORT, 1'b0);
      4'd7:    s = mk_step(1'b1, BYTE_DISP_CTRL[7:4], WAIT_NONE, 1'b0);
      4'd8:    s = mk_step(1'b1, BYTE_DISP_CTRL[3:0], WAIT_SHORT, 1'b0);
      4'd9:    s = mk_step(1'b1, BYTE_CLEAR[7:4], WAIT_NONE, 1'b0);
      4'd10:   s = mk_step(1'b1, BYTE_CLEAR[3:0], WAIT_LONG, 1'b0);
      4'd11:   s = mk_step(1'b1, BYTE_ENTRY[7:4], WAIT_NONE, 1'b0);
      4'd12:   s = mk_step(1'b1, BYTE_ENTRY[3:0], WAIT_SHORT, 1'b1);
      default: s = mk_step(1'b0, 4'h0, WAIT_NONE, 1'b1);
    endcase
    return s;
  endfunction

endpackage

[hdl/lcd4_req_if.sv]
interface lcd4_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_code;
  logic [4:0] column;
  logic [1:0] row;
  logic       display_on;
  logic       cursor_shown;
  logic       cursor_blink;

  modport source (
    output valid, kind, char_code, column, row, display_on, cursor_shown, cursor_blink,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, column, row, display_on, cursor_shown, cursor_blink,
    output ready
  );
endinterface

interface lcd4_step_if;
  logic       valid;
  logic       ready;
  logic       strobe_res;
  logic       reg_select;
  logic [3:0] nibble;
  logic [7:0] wait_ticks;
  logic       last;

  modport source (
    output valid, strobe_res, reg_select, nibble, wait_ticks, last,
    input  ready
  );
  modport sink (
    input  valid, strobe_res, reg_select, nibble, wait_ticks, last,
    output ready
  );
endinterface

[hdl/lcd4_ctrl.sv]
module lcd4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lcd4_pkg::status_t status,
  output lcd4_pkg::cmd_t    cmd
);
  import lcd4_pkg::*;
  `include "char_lcd_4bit_command_sequencer_macros.svh"

  typedef enum logic {IDLE, RUN} state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;

  assign req_ready   = (state == IDLE);
  assign cmd.capture = req_valid && req_ready;
  assign cmd.load    = (state == RUN) && status.out_free;
  assign cmd.idx     = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          // drop unused kinds without emitting anything
          if (cmd.capture && status.kind_ok) begin
            state <= RUN;
            idx   <= '0;
          end
        end
        RUN: begin
          if (cmd.load) begin
            if (status.step_last) begin
              state <= IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `LCD4_ASSERT_NEXT(a_start, cmd.capture && status.kind_ok, state == RUN && idx == '0,
                    "request did not start at step zero")
  `LCD4_ASSERT_NEXT(a_advance, cmd.load && !status.step_last,
                    state == RUN && idx == $past(idx) + 1'b1, "step index did not advance")
  `LCD4_ASSERT_NOW(a_idx_range, state == RUN, idx < IDX_W'(INIT_STEPS),
                   "step index ran past the longest sequence")

endmodule

[hdl/lcd4_datapath.sv]
module lcd4_datapath #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  lcd4_pkg::req_t    req,
  input  lcd4_pkg::cmd_t    cmd,
  output lcd4_pkg::status_t status,
  output lcd4_pkg::step_t   rsp,
  output logic              rsp_valid,
  input  logic              rsp_ready
);
  import lcd4_pkg::*;

  localparam logic [5:0] COL_MAX = 6'(COLUMNS);

  logic [2:0] kind_q;
  logic [7:0] byte_q;
  logic [7:0] byte_next;
  logic [5:0] col_ext;
  logic [5:0] col_sat;
  logic [4:0] col_m1;
  logic       line2;
  step_t      step_cur;

  // saturate position into the visible window
  always_comb begin
    col_ext = {1'b0, req.column};
    if (req.column == 5'd0) begin
      col_sat = 6'd1;
    end else if (col_ext > COL_MAX) begin
      col_sat = COL_MAX;
    end else begin
      col_sat = col_ext;
    end
    col_m1 = col_sat[4:0] - 5'd1;
    line2  = (req.row >= 2'd2);
  end

  always_comb begin
    unique case (req.kind)
      KIND_WRITE: byte_next = req.char_code;
      KIND_POS:   byte_next = BYTE_SET_DDRAM + (line2 ? LINE2_OFFSET : 8'h00)
                              + {3'b000, col_m1};
      KIND_CTRL:  byte_next = BYTE_DISP_CTRL | {5'b00000, req.display_on,
                                                req.cursor_shown, req.cursor_blink};
      KIND_CLEAR: byte_next = BYTE_CLEAR;
      default:    byte_next = 8'h00;
    endcase
  end

  always_comb begin
    if (kind_q == KIND_INIT) begin
      step_cur = init_step(cmd.idx);
    end else begin
      // high nibble first, no wait; low nibble closes the request
      step_cur.strobe_res = 1'b1;
      step_cur.reg_select = (kind_q == KIND_WRITE);
      step_cur.nibble     = cmd.idx[0] ? byte_q[3:0] : byte_q[7:4];
      step_cur.last       = cmd.idx[0];
      if (!cmd.idx[0]) begin
        step_cur.wait_ticks = WAIT_NONE;
      end else if (kind_q == KIND_CLEAR) begin
        step_cur.wait_ticks = WAIT_CLEAR;
      end else begin
        step_cur.wait_ticks = WAIT_SHORT;
      end
    end
  end

  assign status.kind_ok   = (req.kind <= KIND_CLEAR);
  assign status.out_free  = !rsp_valid || rsp_ready;
  assign status.step_last = step_cur.last;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= req.kind;
      byte_q <= byte_next;
    end
    if (cmd.load) begin
      rsp <= step_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[hdl/char_lcd_4bit_command_sequencer.sv]
// Four-bit command sequencer for an HD44780-style character display. Each request
// on req becomes a run of bus steps on rsp, one step per cycle while rsp is ready:
// a step strobes enable with reg_select and a nibble for D7..D4, or only waits,
// and carries the wait in 100 us ticks to hold afterward; last marks the final
// step. A request is taken when req is valid and ready, and its steps are then loaded
// in order from step zero: initialise has 13 steps, while write character, set
// position, display control and clear have two (high nibble, then low); a step
// that rsp holds unaccepted stalls the loading. Kinds 5 to 7 are taken and produce
// nothing. The controller's step counter loads one step per cycle into the output
// register while rsp is free, and req is ready again once the last step of a
// request has been loaded. Set position saturates the column to 1..COLUMNS and the
// row to 1..2.
module char_lcd_4bit_command_sequencer #(
  parameter int unsigned COLUMNS = 16
) (
  input logic         clk,
  input logic         rst,
  lcd4_req_if.sink    req,
  lcd4_step_if.source rsp
);
  import lcd4_pkg::*;

  req_t    req_data;
  step_t   rsp_data;
  cmd_t    cmd;
  status_t status;
  logic    rsp_valid;

  assign req_data.kind         = req.kind;
  assign req_data.char_code    = req.char_code;
  assign req_data.column       = req.column;
  assign req_data.row          = req.row;
  assign req_data.display_on   = req.display_on;
  assign req_data.cursor_shown = req.cursor_shown;
  assign req_data.cursor_blink = req.cursor_blink;

  lcd4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcd4_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req_data),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready)
  );

  assign rsp.valid      = rsp_valid;
  assign rsp.strobe_res = rsp_data.strobe_res;
  assign rsp.reg_select = rsp_data.reg_select;
  assign rsp.nibble     = rsp_data.nibble;
  assign rsp.wait_ticks = rsp_data.wait_ticks;
  assign rsp.last       = rsp_data.last;

endmodule
